>>> rtl/core/smbox_pkg.sv
// ----------------------------------------------------------------------------
// Shared mailbox package
// Field widths, bus command codes, mailbox addresses and shared types.
// ----------------------------------------------------------------------------
package smbox_pkg;

  localparam int unsigned SHARED_BYTES  = 1024;
  localparam int unsigned SH_AW         = 10;
  localparam int unsigned RAM_BYTES_DEF = 524288;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned DATA_W = 8;

  // Private region: physical bit 19 set, offset taken from the low 19 bits
  localparam int unsigned PRIV_AW = 19;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_HOST_WR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HOST_RD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COP_WR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COP_RD  = 2'd3;

  localparam logic [SH_AW-1:0]  BELL_HOST_IDX = 10'h3FF;
  localparam logic [ADDR_W-1:0] BELL_COP_IN   = 20'h003FF;
  localparam logic [ADDR_W-1:0] BELL_COP_OUT  = 20'h003FE;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } acc_t;

endpackage

>>> rtl/core/shared_mailbox_with_doorbells.sv
// ----------------------------------------------------------------------------
// Shared mailbox with doorbells
// Host/coprocessor mailbox: 1 KiB shared store, private coprocessor RAM,
// doorbell flags each way and host control of the coprocessor reset.
// ----------------------------------------------------------------------------
// Pipeline: 3 register stages from input acceptance to result valid.
// Throughput: one item per cycle unless the output stalls; memories and flags
// are touched in a single stage, so back-to-back accesses see each other
// without forwarding. Reset: flags return to held-reset / no doorbells, then
// a clearing pass zeroes all 1024 shared bytes while s_axis_tready stays low.
module shared_mailbox_with_doorbells
  import smbox_pkg::*;
#(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [19:0] address, [27:20] write_data, [31:28] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] read_data, [8] cpu_held_reset, [9] irq_to_coprocessor,
  // [10] irq_to_host, [15:11] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned RamAw      = $clog2(RAM_BYTES);
  // Quotient of a 19-bit offset by RAM_BYTES via a reciprocal; with this
  // shift the estimate is exact over the whole offset range.
  localparam int unsigned RecipShift = PRIV_AW + RamAw;
  localparam int unsigned QuotW      = $clog2((1 << PRIV_AW) / RAM_BYTES + 1);
  localparam int unsigned ProdW      = RecipShift + QuotW;
  localparam logic [ProdW-1:0] RecipM =
    ProdW'(((64'd1 << RecipShift) + 64'(RAM_BYTES) - 64'd1) / 64'(RAM_BYTES));

  // ---------------- handshake chain ----------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_ready, s2_ready, s1_ready, s2_go, s1_go, in_fire;
  logic clearing;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s2_ready      = !s2_valid_q || out_ready;
  assign s2_go         = s2_valid_q && out_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s1_go         = s1_valid_q && s2_ready;
  assign s_axis_tready = s1_ready && !clearing;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_fire;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (out_ready) out_valid_q <= s2_valid_q;
    end
  end

  // ---------------- stage 1: reciprocal multiply ----------------
  acc_t             in_acc;
  logic [ProdW-1:0] recip_prod;
  acc_t             s1_q;
  logic [QuotW-1:0] s1_quot_q;

  assign in_acc.cmd   = s_axis_tuser[CMD_W-1:0];
  assign in_acc.addr  = s_axis_tdata[ADDR_W-1:0];
  assign in_acc.wdata = s_axis_tdata[ADDR_W +: DATA_W];
  assign recip_prod   = ProdW'(in_acc.addr[PRIV_AW-1:0]) * RecipM;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q      <= in_acc;
      s1_quot_q <= recip_prod[RecipShift +: QuotW];
    end
  end

  // ---------------- stage 2: quotient times size ----------------
  acc_t               s2_q;
  logic [PRIV_AW-1:0] s2_qr_q;
  logic [PRIV_AW:0]   qr_full;

  assign qr_full = (PRIV_AW + 1)'(s1_quot_q) * (PRIV_AW + 1)'(RAM_BYTES);

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_q    <= s1_q;
      s2_qr_q <= qr_full[PRIV_AW-1:0];
    end
  end

  // ---------------- memory stage: decode, access, flags ----------------
  logic               is_host, is_write, is_read, is_shared;
  logic [SH_AW-1:0]   host_idx, sh_addr;
  logic [PRIV_AW-1:0] priv_off;
  logic [RamAw-1:0]   priv_idx;

  assign is_host   = (s2_q.cmd == CMD_HOST_WR) || (s2_q.cmd == CMD_HOST_RD);
  assign is_write  = (s2_q.cmd == CMD_HOST_WR) || (s2_q.cmd == CMD_COP_WR);
  assign is_read   = !is_write;
  // coprocessor addresses below 0x80000 alias the shared store
  assign is_shared = is_host || !s2_q.addr[ADDR_W-1];
  assign host_idx  = {s2_q.addr[1:0], s2_q.addr[15:8]};
  assign sh_addr   = is_host ? host_idx : s2_q.addr[SH_AW-1:0];
  assign priv_off  = s2_q.addr[PRIV_AW-1:0] - s2_qr_q;
  assign priv_idx  = priv_off[RamAw-1:0];

  logic reset_held_q, db_in_q, db_out_q;
  logic reset_held_d, db_in_d, db_out_d;

  always_comb begin
    reset_held_d = reset_held_q;
    db_in_d      = db_in_q;
    db_out_d     = db_out_q;
    if (is_host) reset_held_d = !s2_q.addr[2];
    if (s2_q.cmd == CMD_HOST_WR && host_idx == BELL_HOST_IDX) db_in_d = 1'b1;
    if (s2_q.cmd == CMD_COP_RD && s2_q.addr == BELL_COP_IN) db_in_d = 1'b0;
    if (s2_q.cmd == CMD_HOST_RD && host_idx == BELL_HOST_IDX) db_out_d = 1'b0;
    if (s2_q.cmd == CMD_COP_WR && s2_q.addr == BELL_COP_OUT) db_out_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_held_q <= 1'b1;
      db_in_q      <= 1'b0;
      db_out_q     <= 1'b0;
    end else if (s2_go) begin
      reset_held_q <= reset_held_d;
      db_in_q      <= db_in_d;
      db_out_q     <= db_out_d;
    end
  end

  // clearing pass over the shared store after reset
  logic [SH_AW:0] clr_cnt_q;

  assign clearing = !clr_cnt_q[SH_AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // shared store
  logic [DATA_W-1:0] shared_mem [SHARED_BYTES];
  logic [DATA_W-1:0] sh_rd_q;
  logic              sh_we, sh_re;
  logic [SH_AW-1:0]  sh_waddr;
  logic [DATA_W-1:0] sh_wdata;

  assign sh_we    = clearing || (s2_go && is_write && is_shared);
  assign sh_re    = s2_go && is_read && is_shared;
  assign sh_waddr = clearing ? clr_cnt_q[SH_AW-1:0] : sh_addr;
  assign sh_wdata = clearing ? '0 : s2_q.wdata;

  always_ff @(posedge clk_i) begin
    if (sh_we) shared_mem[sh_waddr] <= sh_wdata;
    if (sh_re) sh_rd_q <= shared_mem[sh_addr];
  end

  // private coprocessor RAM
  logic [DATA_W-1:0] priv_mem [RAM_BYTES];
  logic [DATA_W-1:0] pr_rd_q;
  logic              pr_we, pr_re;

  assign pr_we = s2_go && is_write && !is_shared;
  assign pr_re = s2_go && is_read && !is_shared;

  always_ff @(posedge clk_i) begin
    if (pr_we) priv_mem[priv_idx] <= s2_q.wdata;
    if (pr_re) pr_rd_q <= priv_mem[priv_idx];
  end

  // ---------------- result register ----------------
  logic out_is_read_q, out_shared_q;

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      out_is_read_q <= is_read;
      out_shared_q  <= is_shared;
    end
  end

  logic [DATA_W-1:0] rd_data;

  assign rd_data = !out_is_read_q ? '0 : (out_shared_q ? sh_rd_q : pr_rd_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, db_out_q && !reset_held_q, db_in_q, reset_held_q, rd_data};

  // ---------------- assertions ----------------
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("item accepted during shared store clearing");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_is_read_q) |-> (m_axis_tdata[DATA_W-1:0] == '0))
    else $error("write result carries nonzero read data");

  a_bell_in_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(db_in_q) |-> $past(s2_go && s2_q.cmd == CMD_HOST_WR))
    else $error("coprocessor doorbell raised without a host write");

  a_bell_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(db_out_q) |-> $past(s2_go && s2_q.cmd == CMD_COP_WR))
    else $error("host doorbell raised without a coprocessor write");

endmodule

>>> tb/sv/tb_shared_mailbox_with_doorbells.sv
// ----------------------------------------------------------------------------
// Shared mailbox with doorbells testbench
// Drives host and coprocessor bus accesses into the mailbox card, predicts
// every result from a behavioral image of the shared store, the private RAM
// and the doorbell and reset flags, and checks each result field by field.
// Both stream sides idle at random; the receiver also holds off for a long
// stretch and the sender pauses twice until all results are back.
// ----------------------------------------------------------------------------
module tb_shared_mailbox_with_doorbells;
  import smbox_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_IDLE     = 12;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct {
    bit                drain;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    int unsigned       idle_after;
  } mbox_access_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic              held;
    logic              bell_in;
    logic              irq_host;
  } mbox_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  shared_mailbox_with_doorbells dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Behavioral image of the card
  logic [DATA_W-1:0] shared_img [SHARED_BYTES] = '{default: '0};
  logic [DATA_W-1:0] priv_img [int unsigned];
  logic              cop_held = 1'b1;
  logic              bell_in  = 1'b0;
  logic              bell_out = 1'b0;

  mbox_access_t      access_q [$];
  mbox_result_t      pending_results [$];
  logic [ADDR_W-1:0] priv_written [$];
  mbox_access_t      cur;
  mbox_result_t      want;
  int unsigned       drv_gap;
  int unsigned       rx_stall;
  bit                rx_steady;
  bit                hold_rx = 1'b0;
  bit                burst_mode;
  int unsigned       queued_n;
  int unsigned       issued_n;
  int unsigned       received_n;
  int unsigned       fail_count;

  function automatic mbox_result_t predict_access(logic [CMD_W-1:0] cmd,
                                                  logic [ADDR_W-1:0] addr,
                                                  logic [DATA_W-1:0] wdata);
    mbox_result_t     res;
    logic [SH_AW-1:0] idx;
    int unsigned      pidx;
    res = '0;
    if (cmd == CMD_HOST_WR || cmd == CMD_HOST_RD) begin
      // swizzled port: bits 1..0 on top of bits 15..8
      idx = {addr[1:0], addr[15:8]};
      cop_held = !addr[2];
      if (cmd == CMD_HOST_WR) begin
        shared_img[idx] = wdata;
        if (idx == BELL_HOST_IDX) bell_in = 1'b1;
      end else begin
        if (idx == BELL_HOST_IDX) bell_out = 1'b0;
        res.rd = shared_img[idx];
      end
    end else begin
      pidx = addr[PRIV_AW-1:0] % RAM_BYTES_DEF;
      if (cmd == CMD_COP_WR) begin
        if (addr == BELL_COP_OUT) bell_out = 1'b1;
        if (addr[ADDR_W-1]) priv_img[pidx] = wdata;
        else shared_img[addr[SH_AW-1:0]] = wdata;
      end else begin
        if (addr == BELL_COP_IN) bell_in = 1'b0;
        if (addr[ADDR_W-1]) res.rd = priv_img[pidx];
        else res.rd = shared_img[addr[SH_AW-1:0]];
      end
    end
    res.held     = cop_held;
    res.bell_in  = bell_in;
    res.irq_host = bell_out && !cop_held;
    return res;
  endfunction

  task automatic flag_mismatch(string field, logic [15:0] got, logic [15:0] exp_val);
    $display("mismatch at result %0d: %s got %0h, expected %0h",
             received_n, field, got, exp_val);
    fail_count++;
  endtask

  task automatic queue_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] wdata);
    mbox_access_t item;
    item.drain      = 1'b0;
    item.cmd        = cmd;
    item.addr       = addr;
    item.wdata      = wdata;
    item.idle_after = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
    access_q.push_back(item);
    if (cmd == CMD_COP_WR && addr[ADDR_W-1]) priv_written.push_back(addr);
    queued_n++;
  endtask

  task automatic queue_drain();
    mbox_access_t item;
    item            = '{default: '0};
    item.drain      = 1'b1;
    access_q.push_back(item);
  endtask

  function automatic logic [ADDR_W-1:0] host_port(logic [SH_AW-1:0] idx, bit run);
    logic [ADDR_W-1:0] a;
    a       = ADDR_W'($urandom);
    a[15:8] = idx[7:0];
    a[1:0]  = idx[9:8];
    a[2]    = run;
    return a;
  endfunction

  // any of the 512 shared aliases below the private region
  function automatic logic [ADDR_W-1:0] cop_alias(logic [SH_AW-1:0] idx);
    return (ADDR_W'($urandom_range(0, 511)) << SH_AW) | ADDR_W'(idx);
  endfunction

  // Driver: one item offered at a time, idle cycles drawn per item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(predict_access(cur.cmd, cur.addr, cur.wdata));
        issued_n++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (drv_gap != 0) begin
          drv_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (access_q.size() != 0 && access_q[0].drain) begin
          if (pending_results.size() == 0) void'(access_q.pop_front());
          s_axis_tvalid <= 1'b0;
        end else if (access_q.size() != 0) begin
          cur = access_q.pop_front();
          s_axis_tdata  <= {4'b0, cur.wdata, cur.addr};
          s_axis_tuser  <= cur.cmd;
          s_axis_tvalid <= 1'b1;
          drv_gap = cur.idle_after;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls per item, plus the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("item with nothing expected", m_axis_tdata, '0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[DATA_W-1:0] !== want.rd)
            flag_mismatch("read_data", 16'(m_axis_tdata[DATA_W-1:0]), 16'(want.rd));
          if (m_axis_tdata[DATA_W] !== want.held)
            flag_mismatch("cpu_held_reset", 16'(m_axis_tdata[DATA_W]), 16'(want.held));
          if (m_axis_tdata[DATA_W+1] !== want.bell_in)
            flag_mismatch("irq_to_coprocessor", 16'(m_axis_tdata[DATA_W+1]),
                          16'(want.bell_in));
          if (m_axis_tdata[DATA_W+2] !== want.irq_host)
            flag_mismatch("irq_to_host", 16'(m_axis_tdata[DATA_W+2]),
                          16'(want.irq_host));
          if (m_axis_tdata[OUT_TDATA_W-1:DATA_W+3] !== '0)
            flag_mismatch("pad bits", 16'(m_axis_tdata[OUT_TDATA_W-1:DATA_W+3]), '0);
        end
        received_n++;
        if (received_n % 64 == 0) rx_steady = ($urandom_range(0, 2) == 0);
        rx_stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      m_axis_tready <= !hold_rx && rx_stall == 0;
    end
  end

  // Long receiver hold-off while the sender is bursting
  initial begin
    while (issued_n < 130) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [SH_AW-1:0] msg_idx [4];
    int unsigned      n_msg;
    bit               drained_mid;
    logic [ADDR_W-1:0] a;

    burst_mode  = 1'b0;
    drained_mid = 1'b0;

    // directed: reset state, doorbells both ways, aliases, reset masking
    queue_access(CMD_HOST_RD, 20'h00000, 8'h00);
    queue_access(CMD_HOST_WR, 20'hFFFFF, 8'hFF);   // bell index, release
    queue_access(CMD_COP_RD, 20'h7FFFF, 8'hFF);    // alias leaves bell set
    queue_access(CMD_COP_RD, BELL_COP_IN, 8'h00);
    queue_access(CMD_COP_WR, 20'h7FFFE, 8'h5A);    // alias rings nothing
    queue_access(CMD_COP_WR, BELL_COP_OUT, 8'hA5);
    queue_access(CMD_HOST_RD, 20'h0FE07, 8'hFF);
    queue_access(CMD_HOST_RD, 20'h0FF03, 8'h00);   // clears, holds reset
    queue_access(CMD_COP_WR, BELL_COP_OUT, 8'h3C); // rings while masked
    queue_access(CMD_HOST_WR, 20'h00004, 8'h00);   // release unmasks irq
    queue_access(CMD_HOST_WR, 20'hF0000, 8'h77);
    queue_access(CMD_COP_RD, 20'h00000, 8'h00);
    queue_access(CMD_COP_RD, 20'h7FC00, 8'hFF);
    queue_access(CMD_COP_WR, 20'h80000, 8'h00);
    queue_access(CMD_COP_WR, 20'hFFFFF, 8'hFF);
    queue_access(CMD_COP_RD, 20'hFFFFF, 8'h00);
    queue_access(CMD_COP_RD, 20'h80000, 8'hFF);
    queue_access(CMD_COP_WR, 20'h7FFFF, 8'h11);
    queue_access(CMD_HOST_RD, 20'h0FF07, 8'h00);
    queue_access(CMD_HOST_WR, 20'h0FF07, 8'h00);
    queue_access(CMD_COP_WR, 20'h803FE, 8'hEE);   // private, no doorbell
    queue_access(CMD_COP_RD, 20'h803FE, 8'h00);
    queue_drain();

    while (queued_n < 720) begin
      burst_mode = (queued_n >= 110 && queued_n < 300) ||
                   (queued_n >= 500 && queued_n < 560);
      if (!drained_mid && queued_n >= 450) begin
        queue_drain();
        drained_mid = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // host posts a message and rings, coprocessor reads and answers
          n_msg = $urandom_range(1, 4);
          for (int i = 0; i < n_msg; i++) begin
            msg_idx[i] = SH_AW'($urandom_range(0, 1021));
            queue_access(CMD_HOST_WR, host_port(msg_idx[i], $urandom_range(0, 5) != 0),
                         DATA_W'($urandom));
          end
          queue_access(CMD_HOST_WR, host_port(BELL_HOST_IDX, 1'b1), DATA_W'($urandom));
          for (int i = 0; i < n_msg; i++)
            queue_access(CMD_COP_RD, cop_alias(msg_idx[i]), DATA_W'($urandom));
          queue_access(CMD_COP_RD, BELL_COP_IN, DATA_W'($urandom));
          queue_access(CMD_COP_WR, BELL_COP_OUT, DATA_W'($urandom));
          queue_access(CMD_HOST_RD, host_port(SH_AW'(BELL_COP_OUT), 1'b1),
                       DATA_W'($urandom));
          queue_access(CMD_HOST_RD, host_port(BELL_HOST_IDX, $urandom_range(0, 3) != 0),
                       DATA_W'($urandom));
        end
        2: queue_access(CMD_HOST_WR, ADDR_W'($urandom), DATA_W'($urandom));
        3: queue_access(CMD_HOST_RD, ADDR_W'($urandom), DATA_W'($urandom));
        4: begin
          case ($urandom_range(0, 3))
            0:       a = BELL_COP_OUT;
            1:       a = BELL_COP_IN;
            default: a = {1'b0, (ADDR_W-1)'($urandom)};
          endcase
          queue_access(CMD_COP_WR, a, DATA_W'($urandom));
        end
        5: begin
          case ($urandom_range(0, 3))
            0:       a = BELL_COP_IN;
            1:       a = cop_alias(SH_AW'(BELL_COP_IN));
            default: a = {1'b0, (ADDR_W-1)'($urandom)};
          endcase
          queue_access(CMD_COP_RD, a, DATA_W'($urandom));
        end
        6: begin
          if ($urandom_range(0, 1) == 0) a = {1'b1, (ADDR_W-1)'($urandom)};
          else a = {1'b1, 15'd0, 4'($urandom)};
          queue_access(CMD_COP_WR, a, DATA_W'($urandom));
        end
        7: begin
          if (priv_written.size() != 0)
            queue_access(CMD_COP_RD,
                         priv_written[$urandom_range(0, priv_written.size() - 1)],
                         DATA_W'($urandom));
          else
            queue_access(CMD_COP_WR, {1'b1, (ADDR_W-1)'($urandom)}, DATA_W'($urandom));
        end
        8: queue_access($urandom_range(0, 1) ? CMD_HOST_WR : CMD_HOST_RD,
                        host_port(BELL_HOST_IDX, $urandom_range(0, 1) != 0),
                        DATA_W'($urandom));
        default: queue_access(CMD_HOST_WR, host_port(SH_AW'($urandom), 1'b1),
                              DATA_W'($urandom));
      endcase
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (access_q.size() != 0 || pending_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
